// ----- rtl/ir_pulse_distance_frame_transmitter_top_macros.svh -----
// Assertion helpers used by the transmitter sequencer.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef IR_PULSE_DISTANCE_FRAME_TRANSMITTER_TOP_MACROS_SVH
`define IR_PULSE_DISTANCE_FRAME_TRANSMITTER_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define IRPD_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define IRPD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/irpd_pkg.sv -----
package irpd_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_POLARITY     = 3'd0,
    REG_CARRIER_HALF = 3'd1,
    REG_START_MARK   = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_START_SPACE  = 3'd4,
    REG_ONE_SPACE    = 3'd5,
    REG_ZERO_SPACE   = 3'd6,
    REG_STOP_SPACE   = 3'd7
  } cfg_reg_t;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Register values after reset.
  localparam logic        PolarityReset    = 1'b1;
  localparam logic [7:0]  CarrierHalfReset = 8'd13;
  localparam logic [8:0]  StartMarkReset   = 9'd342;
  localparam logic [8:0]  BitMarkReset     = 9'd22;
  localparam logic [15:0] StartSpaceReset  = 16'd4500;
  localparam logic [15:0] OneSpaceReset    = 16'd1600;
  localparam logic [15:0] ZeroSpaceReset   = 16'd600;
  localparam logic [15:0] StopSpaceReset   = 16'd20000;

  // Symbol positions within the 70-symbol frame.
  localparam logic [6:0] SymStart     = 7'd0;
  localparam logic [6:0] SymLowLast   = 7'd32;
  localparam logic [6:0] SymLinkZeroA = 7'd33;
  localparam logic [6:0] SymLinkOne   = 7'd34;
  localparam logic [6:0] SymLinkZeroB = 7'd35;
  localparam logic [6:0] SymLinkStop  = 7'd36;
  localparam logic [6:0] SymHighLast  = 7'd68;
  localparam logic [6:0] SymbolTotal  = 7'd70;
  localparam logic [6:0] LowBitBase   = 7'd64;
  localparam logic [6:0] HighBitBase  = 7'd68;

  // Symbol kinds.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_ZERO  = 2'd2,
    KIND_STOP  = 2'd3
  } symbol_kind_t;

  typedef struct packed {
    logic        polarity;
    logic [7:0]  carrier_half;
    logic [8:0]  start_mark;
    logic [8:0]  bit_mark;
    logic [15:0] start_space;
    logic [15:0] one_space;
    logic [15:0] zero_space;
    logic [15:0] stop_space;
  } irpd_cfg_t;

  typedef struct packed {
    logic pin_level;
    logic busy;
    logic done;
    logic rejected;
  } irpd_result_t;

endpackage

// ----- rtl/irpd_sequencer.sv -----
`include "ir_pulse_distance_frame_transmitter_top_macros.svh"

module irpd_sequencer
  import irpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  irpd_cfg_t    cfg,
  input  logic         step,
  input  logic         req_type,
  input  logic [63:0]  frame_data,
  output irpd_result_t res
);

  // Frame state.
  logic [63:0] bit_shift, bit_shift_next;
  logic [6:0]  symbol_index, symbol_index_next;
  logic        in_space, in_space_next;
  logic [8:0]  period_count, period_count_next;
  logic [16:0] tick_count, tick_count_next;
  logic        carrier_on, carrier_on_next;
  logic        sending, sending_next;

  symbol_kind_t kind;
  logic [6:0]   low_pos;
  logic [6:0]   high_pos;
  logic [7:0]   half_len;
  logic [8:0]   mark_len;
  logic [15:0]  space_len;
  logic [16:0]  cur_len;
  logic [16:0]  tick_inc;
  logic         mark_last;
  logic         idle_level;
  logic         cur_level;

  // Classify the current symbol; data bits go MSB first.
  always_comb begin
    low_pos  = LowBitBase - symbol_index;
    high_pos = HighBitBase - symbol_index;
    if (symbol_index == SymStart) begin
      kind = KIND_START;
    end else if (symbol_index <= SymLowLast) begin
      kind = bit_shift[low_pos[5:0]] ? KIND_ONE : KIND_ZERO;
    end else if (symbol_index == SymLinkZeroA || symbol_index == SymLinkZeroB) begin
      kind = KIND_ZERO;
    end else if (symbol_index == SymLinkOne) begin
      kind = KIND_ONE;
    end else if (symbol_index == SymLinkStop || symbol_index > SymHighLast) begin
      kind = KIND_STOP;
    end else begin
      kind = bit_shift[high_pos[5:0]] ? KIND_ONE : KIND_ZERO;
    end
  end

  // Lengths for the current symbol; a zero carrier half or mark count counts as one.
  always_comb begin
    half_len = (cfg.carrier_half == 8'd0) ? 8'd1 : cfg.carrier_half;
    if (kind == KIND_START) begin
      mark_len = (cfg.start_mark == 9'd0) ? 9'd1 : cfg.start_mark;
    end else begin
      mark_len = (cfg.bit_mark == 9'd0) ? 9'd1 : cfg.bit_mark;
    end
    case (kind)
      KIND_START: space_len = cfg.start_space;
      KIND_ONE:   space_len = cfg.one_space;
      KIND_ZERO:  space_len = cfg.zero_space;
      default:    space_len = cfg.stop_space;
    endcase
    cur_len = {9'd0, half_len};
    if (!carrier_on && in_space) begin
      cur_len = {9'd0, half_len} + {1'b0, space_len};
    end
    tick_inc  = tick_count + 17'd1;
    mark_last = ({1'b0, period_count} + 10'd1) >= {1'b0, mark_len};
  end

  assign idle_level = ~cfg.polarity;
  assign cur_level  = (sending && carrier_on) ? cfg.polarity : idle_level;

  // Next state and the result of the offered item.
  always_comb begin
    bit_shift_next    = bit_shift;
    symbol_index_next = symbol_index;
    in_space_next     = in_space;
    period_count_next = period_count;
    tick_count_next   = tick_count;
    carrier_on_next   = carrier_on;
    sending_next      = sending;
    res.pin_level     = cur_level;
    res.busy          = 1'b0;
    res.done          = 1'b0;
    res.rejected      = 1'b0;

    if (req_type) begin
      res.busy = 1'b1;
      if (sending) begin
        res.rejected = 1'b1;
      end else begin
        bit_shift_next    = frame_data;
        symbol_index_next = SymStart;
        in_space_next     = 1'b0;
        period_count_next = 9'd0;
        tick_count_next   = 17'd0;
        carrier_on_next   = 1'b1;
        sending_next      = 1'b1;
        res.pin_level     = cfg.polarity;
      end
    end else if (sending) begin
      res.busy        = 1'b1;
      tick_count_next = tick_inc;
      if (tick_inc >= cur_len) begin
        tick_count_next = 17'd0;
        if (carrier_on) begin
          carrier_on_next = 1'b0;
          in_space_next   = mark_last;
        end else if (in_space) begin
          in_space_next     = 1'b0;
          period_count_next = 9'd0;
          if (symbol_index + 7'd1 >= SymbolTotal) begin
            symbol_index_next = SymStart;
            sending_next      = 1'b0;
            res.done          = 1'b1;
          end else begin
            symbol_index_next = symbol_index + 7'd1;
            carrier_on_next   = 1'b1;
          end
        end else begin
          period_count_next = period_count + 9'd1;
          carrier_on_next   = 1'b1;
        end
      end
    end
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift    <= '0;
      symbol_index <= '0;
      in_space     <= 1'b0;
      period_count <= '0;
      tick_count   <= '0;
      carrier_on   <= 1'b0;
      sending      <= 1'b0;
    end else if (step) begin
      bit_shift    <= bit_shift_next;
      symbol_index <= symbol_index_next;
      in_space     <= in_space_next;
      period_count <= period_count_next;
      tick_count   <= tick_count_next;
      carrier_on   <= carrier_on_next;
      sending      <= sending_next;
    end
  end

  // The extended space is always part of an off half.
  `IRPD_CHECK(a_space_off, !(in_space && carrier_on), "space while carrier on")
  // The symbol counter never runs past the frame.
  `IRPD_CHECK(a_symbol_range, symbol_index < SymbolTotal, "symbol index out of range")
  // A finished frame leaves the sequencer idle and rewound.
  `IRPD_CHECK_NEXT(a_done_idle, step && res.done,
                   !sending && !carrier_on && symbol_index == SymStart,
                   "sequencer not idle after frame end")

endmodule

// ----- rtl/ir_pulse_distance_frame_transmitter_top.sv -----
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   req_type, frame_data
// out       output     out_valid/out_stall pin_level, busy_res, frame_done, start_rejected
// cfg       input      cfg_we              cfg_index, cfg_data
//
// One item is taken per clock while in_stall is low; its result appears in the output
// register on the next cycle, the single result register after the sequencer logic.
// Reset is synchronous: configuration registers take their defaults; the transmitter idles.
// in_stall is high only while the result register is full and out_stall holds it.
module ir_pulse_distance_frame_transmitter_top
  import irpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [63:0]              frame_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     pin_level,
  output logic                     busy_res,
  output logic                     frame_done,
  output logic                     start_rejected,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  irpd_cfg_t    cfg;
  irpd_result_t res;
  logic         accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polarity     <= PolarityReset;
      cfg.carrier_half <= CarrierHalfReset;
      cfg.start_mark   <= StartMarkReset;
      cfg.bit_mark     <= BitMarkReset;
      cfg.start_space  <= StartSpaceReset;
      cfg.one_space    <= OneSpaceReset;
      cfg.zero_space   <= ZeroSpaceReset;
      cfg.stop_space   <= StopSpaceReset;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLARITY:     cfg.polarity     <= cfg_data[0];
        REG_CARRIER_HALF: cfg.carrier_half <= cfg_data[7:0];
        REG_START_MARK:   cfg.start_mark   <= cfg_data[8:0];
        REG_BIT_MARK:     cfg.bit_mark     <= cfg_data[8:0];
        REG_START_SPACE:  cfg.start_space  <= cfg_data;
        REG_ONE_SPACE:    cfg.one_space    <= cfg_data;
        REG_ZERO_SPACE:   cfg.zero_space   <= cfg_data;
        REG_STOP_SPACE:   cfg.stop_space   <= cfg_data;
        default: ;
      endcase
    end
  end

  // An item is taken whenever the result register can move on.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  irpd_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (accept),
    .req_type   (req_type),
    .frame_data (frame_data),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_level      <= res.pin_level;
      busy_res       <= res.busy;
      frame_done     <= res.done;
      start_rejected <= res.rejected;
    end
  end

endmodule

// ----- test/tb.sv -----
module tb;
  import irpd_pkg::*;

  // Request codes carried by req_type.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Percent of cycles on which a side idles outside the steady stretch.
  localparam int unsigned IDLE_PCT = 31;

  typedef struct packed {
    logic        req;
    logic [63:0] data;
  } tx_item_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = 1'b0;
  logic [63:0]              frame_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     pin_level;
  logic                     busy_res;
  logic                     frame_done;
  logic                     start_rejected;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  tx_item_t     pending_items[$];
  irpd_result_t expected_results[$];
  tx_item_t     on_wire;
  irpd_result_t want;
  int           sent_count = 0;
  int           error_count = 0;
  logic         steady;

  // Register values as the block holds them.
  irpd_cfg_t    cfg_shadow;

  // Transmitter state as the block should hold it.
  logic [63:0]  tx_shift = '0;
  logic [6:0]   tx_symbol = '0;
  logic         tx_gap = 1'b0;
  logic [8:0]   tx_periods = '0;
  logic [16:0]  tx_ticks = '0;
  logic         tx_carrier = 1'b0;
  logic         tx_busy = 1'b0;

  ir_pulse_distance_frame_transmitter_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .frame_data     (frame_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_level      (pin_level),
    .busy_res       (busy_res),
    .frame_done     (frame_done),
    .start_rejected (start_rejected),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Both sides run without idling for a stretch of the item stream.
  assign steady = (sent_count >= 200) && (sent_count < 400);

  // Pin level for the current carrier half, or the off level when idle.
  function automatic logic pin_now();
    return (tx_busy && tx_carrier) ? cfg_shadow.polarity : !cfg_shadow.polarity;
  endfunction

  // Advances the transmitter by one item and returns the result it should produce.
  function automatic irpd_result_t advance_transmitter(logic req, logic [63:0] data);
    irpd_result_t res;
    symbol_kind_t kind;
    int unsigned  half_len;
    int unsigned  mark_len;
    int unsigned  span;
    res = '0;
    if (req == REQ_START) begin
      if (tx_busy) begin
        res.rejected = 1'b1;
      end else begin
        tx_shift   = data;
        tx_symbol  = SymStart;
        tx_gap     = 1'b0;
        tx_periods = '0;
        tx_ticks   = '0;
        tx_carrier = 1'b1;
        tx_busy    = 1'b1;
      end
      res.pin_level = pin_now();
      res.busy      = 1'b1;
    end else begin
      res.pin_level = pin_now();
      if (tx_busy) begin
        res.busy = 1'b1;
        // Classify the symbol being sent.
        if (tx_symbol == SymStart) begin
          kind = KIND_START;
        end else if (tx_symbol <= SymLowLast) begin
          kind = tx_shift[LowBitBase - tx_symbol] ? KIND_ONE : KIND_ZERO;
        end else if (tx_symbol == SymLinkOne) begin
          kind = KIND_ONE;
        end else if (tx_symbol == SymLinkZeroA || tx_symbol == SymLinkZeroB) begin
          kind = KIND_ZERO;
        end else if (tx_symbol == SymLinkStop || tx_symbol > SymHighLast) begin
          kind = KIND_STOP;
        end else begin
          kind = tx_shift[HighBitBase - tx_symbol] ? KIND_ONE : KIND_ZERO;
        end
        // A zero carrier half or mark count behaves as one.
        half_len = (cfg_shadow.carrier_half == 0) ? 1 : cfg_shadow.carrier_half;
        mark_len = (kind == KIND_START) ? cfg_shadow.start_mark : cfg_shadow.bit_mark;
        if (mark_len == 0) mark_len = 1;
        case (kind)
          KIND_START: span = cfg_shadow.start_space;
          KIND_ONE:   span = cfg_shadow.one_space;
          KIND_ZERO:  span = cfg_shadow.zero_space;
          default:    span = cfg_shadow.stop_space;
        endcase
        if (!tx_carrier && tx_gap) half_len = half_len + span;
        tx_ticks = tx_ticks + 1'b1;
        // A half ends once its tick count reaches the current length.
        if (tx_ticks >= half_len) begin
          tx_ticks = '0;
          if (tx_carrier) begin
            tx_carrier = 1'b0;
            tx_gap = (tx_periods + 1 >= mark_len);
          end else if (tx_gap) begin
            tx_gap     = 1'b0;
            tx_periods = '0;
            tx_symbol  = tx_symbol + 1'b1;
            if (tx_symbol >= SymbolTotal) begin
              tx_symbol = SymStart;
              tx_busy   = 1'b0;
              res.done  = 1'b1;
            end else begin
              tx_carrier = 1'b1;
            end
          end else begin
            tx_periods = tx_periods + 1'b1;
            tx_carrier = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

  // Driver: presents queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                advance_transmitter(on_wire.req, on_wire.data));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_wire = pending_items.pop_front();
          in_valid   <= 1'b1;
          req_type   <= on_wire.req;
          frame_data <= on_wire.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic expected_bit, logic actual_bit);
    if (actual_bit !== expected_bit) begin
      $error("%s expected %0b actual %0b", name, expected_bit, actual_bit);
      error_count++;
    end
  endtask

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: pin_level %0b busy_res %0b", pin_level, busy_res);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pin_level", want.pin_level, pin_level);
          check_field("busy_res", want.busy, busy_res);
          check_field("frame_done", want.done, frame_done);
          check_field("start_rejected", want.rejected, start_rejected);
        end
      end
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic add_item(logic req, logic [63:0] data);
    tx_item_t item;
    item.req  = req;
    item.data = data;
    pending_items.insert(pending_items.size(), item);
  endtask

  // Mostly ticks, with the odd start request carrying random frame bytes.
  task automatic add_random(int count, int unsigned start_pct);
    for (int i = 0; i < count; i++) begin
      add_item(($urandom_range(99) < start_pct) ? REQ_START : REQ_TICK, {$urandom, $urandom});
    end
  endtask

  // Waits until every queued item has been sent and every result checked.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataWidth-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // Writes every register; the block is drained, so no item sees a partial set.
  task automatic apply_settings(irpd_cfg_t c);
    write_reg(REG_POLARITY, CfgDataWidth'(c.polarity));
    write_reg(REG_CARRIER_HALF, CfgDataWidth'(c.carrier_half));
    write_reg(REG_START_MARK, CfgDataWidth'(c.start_mark));
    write_reg(REG_BIT_MARK, CfgDataWidth'(c.bit_mark));
    write_reg(REG_START_SPACE, c.start_space);
    write_reg(REG_ONE_SPACE, c.one_space);
    write_reg(REG_ZERO_SPACE, c.zero_space);
    write_reg(REG_STOP_SPACE, c.stop_space);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow = c;
    @(negedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    irpd_cfg_t c;
    cfg_shadow = {PolarityReset, CarrierHalfReset, StartMarkReset, BitMarkReset,
                  StartSpaceReset, OneSpaceReset, ZeroSpaceReset, StopSpaceReset};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: idle tick, a start, ticks into the off half, starts while busy.
    add_item(REQ_TICK, '1);
    add_item(REQ_START, '1);
    repeat (15) add_item(REQ_TICK, 64'h0);
    add_item(REQ_START, 64'h0);
    add_item(REQ_START, 64'hA5A5_5A5A_F00F_0FF0);
    repeat (3) add_item(REQ_TICK, '1);
    wait_drained();

    // Lowest settings written mid-frame; a zero carrier half or mark count acts as one.
    apply_settings('{1'b0, 8'd0, 9'd0, 9'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    repeat (150) add_item(REQ_TICK, '1);
    add_item(REQ_START, 64'h0);
    repeat (145) add_item(REQ_TICK, '1);
    add_random(100, 3);
    wait_drained();

    // Small random settings so that frames finish and restart.
    repeat (5) begin
      c.polarity     = 1'($urandom_range(1));
      c.carrier_half = 8'($urandom_range(2));
      c.start_mark   = 9'($urandom_range(2));
      c.bit_mark     = 9'($urandom_range(2));
      c.start_space  = 16'($urandom_range(6));
      c.one_space    = 16'($urandom_range(3));
      c.zero_space   = 16'($urandom_range(3));
      c.stop_space   = 16'($urandom_range(8));
      apply_settings(c);
      add_random(60, 2);
      wait_drained();
    end

    // Short marks with one-tick spaces.
    apply_settings('{1'b1, 8'd1, 9'd1, 9'd1, 16'd1, 16'd1, 16'd1, 16'd1});
    add_random(120, 2);
    wait_drained();

    // Largest settings.
    apply_settings('{1'b1, 8'd255, 9'd511, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    add_item(REQ_START, '1);
    add_random(40, 5);
    wait_drained();

    // Short carrier with the longest spaces.
    apply_settings('{1'b0, 8'd1, 9'd1, 9'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    add_random(40, 5);
    wait_drained();

    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
